FILE: rtl/core/scbc_pkg.sv
// Shared types and constants of the size class block cache.
// Used by the controller, the datapath and the checker; depends on nothing.

package scbc_pkg;

  // Request commands.
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // Result status codes.
  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StTooBig = 2'd1;
  localparam logic [1:0] StEmpty  = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  // Block size of class 0 in bytes; class i holds MinClassBytes << i.
  localparam int unsigned MinClassBytes = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the request fields and its class.
    logic exec;     // Update the stack and load status and class.
    logic load_rd;  // Load the popped address into the output register.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_read; // The captured request is an alloc that pops an entry.
  } dp_stat_t;

endpackage

FILE: rtl/core/scbc_ctrl.sv
// Controller state machine of the size class block cache.
// Sequences capture, execute and read-back; uses scbc_pkg for its command types.

module scbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  scbc_pkg::dp_stat_t    stat_i,
  output scbc_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] StateIdle  = 2'd0;
  localparam logic [1:0] StateExec  = 2'd1;
  localparam logic [1:0] StateRdata = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when it is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StateIdle);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    cmd_o.capture   = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.load_rd   = 1'b0;
    unique case (state_q)
      StateIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StateExec;
        end
      end
      StateExec: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.pop_read ? StateRdata : StateIdle;
        end
      end
      StateRdata: begin
        cmd_o.load_rd = 1'b1;
        state_d       = StateIdle;
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  // Output valid flag: cleared on a transfer, set when a result is loaded.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((cmd_o.exec && !stat_i.pop_read) || cmd_o.load_rd) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/scbc_datapath.sv
// Datapath of the size class block cache: class pick, per-class counts,
// the stack memory and the result register. Uses scbc_pkg.

module scbc_datapath #(
  parameter int NUM_CLASSES = 10,
  parameter int STACK_DEPTH = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scbc_pkg::ctrl_cmd_t   cmd_i,
  output scbc_pkg::dp_stat_t    stat_o,
  input  logic                  cmd_in_i,
  input  logic [31:0]           req_size_i,
  input  logic [47:0]           block_addr_i,
  output logic [1:0]            status_o,
  output logic [47:0]           out_addr_o,
  output logic [3:0]            size_class_o
);

  localparam int ClsW    = $clog2(NUM_CLASSES + 1);
  localparam int ClsIdxW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CntW    = $clog2(STACK_DEPTH + 1);
  localparam int IdxW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int Entries = NUM_CLASSES * STACK_DEPTH;
  localparam int MemAW   = (Entries > 1) ? $clog2(Entries) : 1;

  logic                 cmd_q;
  logic [47:0]          addr_q;
  logic [ClsW-1:0]      cls_q, cls_d;
  logic [CntW-1:0]      cnt_q [NUM_CLASSES];
  logic [ADDR_BITS-1:0] mem [Entries];
  logic [ADDR_BITS-1:0] rd_q;
  logic [1:0]           status_q, status_d;
  logic [47:0]          out_addr_q;
  logic [ClsW-1:0]      out_cls_q;

  logic [ClsIdxW-1:0]   cls_idx;
  logic [CntW-1:0]      cur_cnt;
  logic                 cls_ok, cnt_zero, cnt_full;
  logic                 do_pop, do_push;
  logic [IdxW-1:0]      stk_idx;
  logic [MemAW-1:0]     mem_addr;

  // First class whose block size covers the request; NUM_CLASSES when none does.
  always_comb begin
    cls_d = ClsW'(NUM_CLASSES);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({1'b0, req_size_i} <= (33'(scbc_pkg::MinClassBytes) << i)) begin
        cls_d = ClsW'(i);
      end
    end
  end

  // Count lookup and the decision for the captured request.
  assign cls_ok   = (cls_q < ClsW'(NUM_CLASSES));
  assign cls_idx  = cls_q[ClsIdxW-1:0];
  assign cur_cnt  = cnt_q[cls_idx];
  assign cnt_zero = (cur_cnt == '0);
  assign cnt_full = (cur_cnt == CntW'(STACK_DEPTH));
  assign do_pop   = cls_ok && (cmd_q == scbc_pkg::CmdAlloc) && !cnt_zero;
  assign do_push  = cls_ok && (cmd_q == scbc_pkg::CmdFree) && !cnt_full;

  assign stat_o.pop_read = do_pop;

  // A pop reads the entry below the count, a push writes the entry at the count.
  assign stk_idx  = do_pop ? IdxW'(cur_cnt - 1'b1) : IdxW'(cur_cnt);
  assign mem_addr = MemAW'(32'(cls_idx) * STACK_DEPTH) + MemAW'(stk_idx);

  always_comb begin
    if (!cls_ok) begin
      status_d = scbc_pkg::StTooBig;
    end else if (cmd_q == scbc_pkg::CmdAlloc) begin
      status_d = cnt_zero ? scbc_pkg::StEmpty : scbc_pkg::StDone;
    end else begin
      status_d = cnt_full ? scbc_pkg::StFull : scbc_pkg::StDone;
    end
  end

  // Per-class counts, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (do_pop) begin
        cnt_q[cls_idx] <= cur_cnt - 1'b1;
      end else if (do_push) begin
        cnt_q[cls_idx] <= cur_cnt + 1'b1;
      end
    end
  end

  // Stack memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_push) begin
      mem[mem_addr] <= ADDR_BITS'(addr_q);
    end
    if (cmd_i.exec && do_pop) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Request capture and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_in_i;
      addr_q <= block_addr_i;
      cls_q  <= cls_d;
    end
    if (cmd_i.exec) begin
      status_q   <= status_d;
      out_cls_q  <= cls_q;
      out_addr_q <= '0;
    end
    if (cmd_i.load_rd) begin
      out_addr_q <= 48'(rd_q);
    end
  end

  assign status_o     = status_q;
  assign out_addr_o   = out_addr_q;
  assign size_class_o = 4'(out_cls_q);

endmodule

FILE: rtl/core/size_class_block_cache.sv
// Top level of the size class block cache: controller plus datapath.
// Depends on scbc_pkg, scbc_ctrl and scbc_datapath.

// The block caches freed block addresses in one LIFO stack per size class,
// class i holding blocks of 8 << i bytes. A free request pushes its address,
// an alloc request pops the top address, and every request gives one result
// with a status, the popped address and the chosen class. A request is
// captured in the idle state and executed in the execute state, which
// waits while the previous result has not been taken; a successful alloc
// then passes through a read-back state, because the stack memory returns
// registered read data. A new request can be captured while the previous
// result waits, but no further one until that request has executed.
// Class counts are cleared by reset; stack entries need no clearing.

module size_class_block_cache #(
  parameter int NUM_CLASSES = 10,
  parameter int STACK_DEPTH = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] req_size_i,
  input  logic [47:0] block_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [47:0] out_addr_o,
  output logic [3:0]  size_class_o
);

  scbc_pkg::ctrl_cmd_t ctrl_cmd;
  scbc_pkg::dp_stat_t  dp_stat;

  // Sequencing of each request.
  scbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  // Class pick, counts, stacks and result register.
  scbc_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .cmd_in_i     (cmd_i),
    .req_size_i   (req_size_i),
    .block_addr_i (block_addr_i),
    .status_o     (status_o),
    .out_addr_o   (out_addr_o),
    .size_class_o (size_class_o)
  );

endmodule

FILE: rtl/core/scbc_checker.sv
// Port-level checker of the size class block cache, bound to the top level.
// Depends on scbc_pkg for the status codes.

module scbc_checker #(
  parameter int NUM_CLASSES = 10
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [47:0] out_addr_o,
  input logic [3:0]  size_class_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_addr_o) && $stable(size_class_o))
  else $error("result changed while stalled");

  // A captured request keeps the input closed for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
  else $error("input accepted twice in a row");

  // Only a successful alloc returns an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != scbc_pkg::StDone) |-> (out_addr_o == 48'd0))
  else $error("address on a failed request");

  // Oversize requests report the out-of-range class, all others a real class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == scbc_pkg::StTooBig) ==
      (size_class_o == 4'(NUM_CLASSES))))
  else $error("class does not match oversize status");

endmodule

bind size_class_block_cache scbc_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_scbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_addr_o   (out_addr_o),
  .size_class_o (size_class_o)
);
